### rtl/periodic_timer_table_defines.svh
// ---------------------------------------------------------------------------
// periodic_timer_table_defines: assertion macros
// Concurrent check wrappers used by the timer table modules; empty when
// synthesizing.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// plain property checked at every clock edge outside reset
`define PTT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");
// implication checked at every clock edge outside reset
`define PTT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");
`else
`define PTT_ASSERT(lbl, clk, rstn, prop)
`define PTT_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/ptt_pkg.sv
// ---------------------------------------------------------------------------
// ptt_pkg: shared types for the periodic timer table
// Field widths, operation and result codes, and the command and result beats
// passed between the front, queue and back.
// ---------------------------------------------------------------------------
package ptt_pkg;

  localparam int unsigned TimersDef   = 16;
  localparam int unsigned TimeBitsDef = 48;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned IVL_W  = 27;
  localparam int unsigned NOW_W  = 48;
  localparam int unsigned KIND_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_TICK = 2'd2
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED   = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_DELETED = 3'd2,
    KIND_FIRED   = 3'd3,
    KIND_DONE    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_FINISH = 2'd2
  } state_e;

  // classified command beat
  typedef struct packed {
    op_e              op;
    logic [IVL_W-1:0] ivl;
    logic [NOW_W-1:0] now;
  } cmd_t;

  // result beat
  typedef struct packed {
    kind_e            kind;
    logic [IVL_W-1:0] ivl;
    logic             last;
  } res_t;

endpackage

### rtl/ptt_ram.sv
// ---------------------------------------------------------------------------
// ptt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module ptt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ptt_front.sv
// ---------------------------------------------------------------------------
// ptt_front: input stage of the timer table
// Takes input beats, drops unused operation codes, trims the time to the
// timer width and offers the command to the queue.
// ---------------------------------------------------------------------------
module ptt_front #(
  parameter int unsigned TIME_BITS = ptt_pkg::TimeBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [ptt_pkg::OP_W-1:0]  operation_i,
  input  logic [ptt_pkg::IVL_W-1:0] interval_ms_i,
  input  logic [ptt_pkg::NOW_W-1:0] now_ms_i,
  output logic                      push_o,
  output ptt_pkg::cmd_t             push_cmd_o,
  input  logic                      full_i
);
  import ptt_pkg::*;

  logic  hold_v_q, hold_v_d;
  cmd_t  hold_q;
  cmd_t  cls_cmd;
  logic  cls_keep;
  logic  accept;

  // classify the incoming beat
  always_comb begin
    cls_cmd     = '0;
    cls_cmd.ivl = interval_ms_i;
    cls_cmd.now = NOW_W'(TIME_BITS'(now_ms_i));
    cls_keep    = 1'b1;
    case (operation_i)
      OP_ADD:  cls_cmd.op = OP_ADD;
      OP_DEL:  cls_cmd.op = OP_DEL;
      OP_TICK: cls_cmd.op = OP_TICK;
      default: cls_keep   = 1'b0;
    endcase
  end

  assign in_stall_o = hold_v_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = hold_v_q;
  assign push_cmd_o = hold_q;

  // holding register toward the queue
  always_comb begin
    hold_v_d = hold_v_q;
    if (accept) begin
      hold_v_d = cls_keep;
    end else if (hold_v_q && !full_i) begin
      hold_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= cls_cmd;
    end
  end

endmodule

### rtl/ptt_queue.sv
// ---------------------------------------------------------------------------
// ptt_queue: two-entry command queue
// Decouples the input stage from the table engine.
// ---------------------------------------------------------------------------
`include "periodic_timer_table_defines.svh"

module ptt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ptt_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output ptt_pkg::cmd_t pop_cmd_o,
  output logic          empty_o
);
  import ptt_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign do_push   = push_i && !full_o;
  assign pop_cmd_o = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (do_push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `PTT_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= 2'd2)
  `PTT_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop_i, cnt_q != 2'd0)

endmodule

### rtl/ptt_back.sv
// ---------------------------------------------------------------------------
// ptt_back: timer table engine
// Scans the slot table one entry a cycle, save stalled tick fires, through a
// registered-read RAM; applies add, delete, tick; drives the result register.
// ---------------------------------------------------------------------------
`include "periodic_timer_table_defines.svh"

module ptt_back #(
  parameter int unsigned TIMERS    = ptt_pkg::TimersDef,
  parameter int unsigned TIME_BITS = ptt_pkg::TimeBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  ptt_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ptt_pkg::res_t res_o
);
  import ptt_pkg::*;

  localparam int unsigned IDXW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int unsigned CNTW = $clog2(TIMERS + 1);
  localparam int unsigned RW   = IVL_W + TIME_BITS;

  state_e              state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [CNTW-1:0]     idx_q, idx_d;
  logic                chk_v_q, chk_v_d;
  logic [IDXW-1:0]     chk_idx_q, chk_idx_d;
  logic                hit_v_q, hit_v_d;
  logic [IDXW-1:0]     hit_idx_q, hit_idx_d;
  logic                free_v_q, free_v_d;
  logic [IDXW-1:0]     free_idx_q, free_idx_d;
  logic [TIMERS-1:0]   slot_valid_q;
  logic                out_v_q, out_v_d;
  res_t                res_q, res_d;
  logic                emit, adv, out_free;
  logic                valid_clr, valid_set;

  logic                ram_we;
  logic [IDXW-1:0]     ram_waddr, ram_raddr;
  logic [RW-1:0]       ram_wdata, ram_rdata;

  logic [TIME_BITS-1:0] now_w, rd_exp, iv_ext;
  logic [IVL_W-1:0]     rd_ivl;
  logic                 slot_on, match, due;

  ptt_ram #(
    .WIDTH (RW),
    .DEPTH (TIMERS),
    .AW    (IDXW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // compare stage on the slot just read
  assign now_w    = TIME_BITS'(cmd_q.now);
  assign rd_ivl   = ram_rdata[TIME_BITS +: IVL_W];
  assign rd_exp   = ram_rdata[TIME_BITS-1:0];
  assign iv_ext   = TIME_BITS'(rd_ivl);
  assign slot_on  = slot_valid_q[chk_idx_q];
  assign match    = slot_on && (rd_ivl == cmd_q.ivl);
  assign due      = slot_on && (now_w >= iv_ext) && (rd_exp < (now_w - iv_ext));
  assign out_free = !out_v_q || !out_stall_i;

  // sequencer: next state, scan pointer and result beat
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    chk_v_d    = chk_v_q;
    chk_idx_d  = chk_idx_q;
    hit_v_d    = hit_v_q;
    hit_idx_d  = hit_idx_q;
    free_v_d   = free_v_q;
    free_idx_d = free_idx_q;
    pop_o      = 1'b0;
    ram_raddr  = chk_idx_q;
    ram_we     = 1'b0;
    ram_waddr  = chk_idx_q;
    ram_wdata  = '0;
    emit       = 1'b0;
    adv        = 1'b0;
    res_d      = res_q;
    valid_clr  = 1'b0;
    valid_set  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          cmd_d    = cmd_i;
          state_d  = ST_SCAN;
          idx_d    = '0;
          chk_v_d  = 1'b0;
          hit_v_d  = 1'b0;
          free_v_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (chk_v_q) begin
          case (cmd_q.op)
            OP_ADD: begin
              adv = 1'b1;
              if (match && !hit_v_q) begin
                hit_v_d   = 1'b1;
                hit_idx_d = chk_idx_q;
              end
              if (!slot_on && !free_v_q) begin
                free_v_d   = 1'b1;
                free_idx_d = chk_idx_q;
              end
            end
            OP_DEL: begin
              adv = 1'b1;
              if (match && !hit_v_q) begin
                hit_v_d   = 1'b1;
                valid_clr = 1'b1;
              end
            end
            OP_TICK: begin
              if (due) begin
                if (out_free) begin
                  adv       = 1'b1;
                  emit      = 1'b1;
                  res_d     = '{kind: KIND_FIRED, ivl: rd_ivl, last: 1'b0};
                  ram_we    = 1'b1;
                  ram_wdata = {rd_ivl, rd_exp + iv_ext};
                end
              end else begin
                adv = 1'b1;
              end
            end
            default: adv = 1'b1;
          endcase
        end
        // issue the next read, or hold the current slot on a stall
        if (!chk_v_q || adv) begin
          if (idx_q != CNTW'(TIMERS)) begin
            ram_raddr = idx_q[IDXW-1:0];
            chk_v_d   = 1'b1;
            chk_idx_d = idx_q[IDXW-1:0];
            idx_d     = idx_q + CNTW'(1);
          end else begin
            chk_v_d = 1'b0;
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          case (cmd_q.op)
            OP_ADD: begin
              if (hit_v_q || free_v_q) begin
                ram_we    = 1'b1;
                ram_waddr = hit_v_q ? hit_idx_q : free_idx_q;
                ram_wdata = {cmd_q.ivl, now_w};
                valid_set = 1'b1;
                res_d     = '{kind: KIND_ADDED, ivl: cmd_q.ivl, last: 1'b1};
              end else begin
                res_d = '{kind: KIND_FULL, ivl: cmd_q.ivl, last: 1'b1};
              end
            end
            OP_DEL:  res_d = '{kind: KIND_DELETED, ivl: cmd_q.ivl, last: 1'b1};
            default: res_d = '{kind: KIND_DONE, ivl: '0, last: 1'b1};
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result register
  always_comb begin
    out_v_d = out_v_q;
    if (emit) begin
      out_v_d = 1'b1;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      chk_v_q  <= 1'b0;
      hit_v_q  <= 1'b0;
      free_v_q <= 1'b0;
      idx_q    <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      chk_v_q  <= chk_v_d;
      hit_v_q  <= hit_v_d;
      free_v_q <= free_v_d;
      idx_q    <= idx_d;
      out_v_q  <= out_v_d;
    end
  end

  // slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else begin
      if (valid_clr) begin
        slot_valid_q[chk_idx_q] <= 1'b0;
      end
      if (valid_set) begin
        slot_valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    chk_idx_q  <= chk_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign res_o       = res_q;

  `PTT_ASSERT_IMPL(a_finish_no_chk, clk_i, rst_ni, state_q == ST_FINISH, !chk_v_q)
  `PTT_ASSERT_IMPL(a_we_phase, clk_i, rst_ni, ram_we,
    (state_q == ST_SCAN && cmd_q.op == OP_TICK) || state_q == ST_FINISH)
  `PTT_ASSERT(a_idx_range, clk_i, rst_ni, idx_q <= CNTW'(TIMERS))
  `PTT_ASSERT_IMPL(a_fired_not_last, clk_i, rst_ni,
    out_v_q && res_q.kind == KIND_FIRED, !res_q.last)

endmodule

### rtl/periodic_timer_table.sv
// ---------------------------------------------------------------------------
// periodic_timer_table: table of periodic millisecond timers
// Add, delete and tick commands on a slot table keyed by interval.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) takes one command beat:
//   operation_i selects add, delete or tick; interval_ms_i names the timer
//   and now_ms_i carries the current time. Operation code 3 is dropped.
//   The output channel (out_valid_o / out_stall_i) returns result beats;
//   last_o marks the final beat of a command. Add and delete give one beat,
//   a tick gives one beat per fired timer and a closing tick-done beat.
//   Every command walks the slot RAM one slot a cycle, except while a tick
//   scan waits on a stalled output. Up to three commands can be buffered
//   ahead of the engine while it works.
//   While out_stall_i is high the held beat stays put and the scan pauses
//   on the slot that wants to fire. Reset clears all slot valid bits at
//   once; the slot RAM needs no clearing pass.
// ---------------------------------------------------------------------------
module periodic_timer_table #(
  parameter int unsigned TIMERS    = ptt_pkg::TimersDef,
  parameter int unsigned TIME_BITS = ptt_pkg::TimeBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ptt_pkg::OP_W-1:0]   operation_i,
  input  logic [ptt_pkg::IVL_W-1:0]  interval_ms_i,
  input  logic [ptt_pkg::NOW_W-1:0]  now_ms_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ptt_pkg::KIND_W-1:0] kind_o,
  output logic [ptt_pkg::IVL_W-1:0]  fired_interval_o,
  output logic                       last_o
);
  import ptt_pkg::*;

  logic push, full, pop, empty;
  cmd_t push_cmd, pop_cmd;
  res_t res;

  // input register and classification
  ptt_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .interval_ms_i (interval_ms_i),
    .now_ms_i      (now_ms_i),
    .push_o        (push),
    .push_cmd_o    (push_cmd),
    .full_i        (full)
  );

  // command queue
  ptt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (empty)
  );

  // table engine
  ptt_back #(
    .TIMERS    (TIMERS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign kind_o           = res.kind;
  assign fired_interval_o = res.ivl;
  assign last_o           = res.last;

endmodule
